>>> rtl/deadband_moving_average_top_assert.svh
// Assertion macros shared by the deadband moving average RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef DEADBAND_MOVING_AVERAGE_TOP_ASSERT_SVH
`define DEADBAND_MOVING_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DMA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deadband moving average: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deadband moving average: next-cycle check failed");

`endif

>>> rtl/dma_pkg.sv
// Types and fixed widths for the deadband moving average.
// No dependencies.
package dma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WSUM_W   = 19;
    localparam int AVG_W    = 20;
    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

    // Per-item view of the window after the update.
    typedef struct packed {
        logic                accepted;
        logic [SAMPLE_W-1:0] newest;
        logic [SAMPLE_W-1:0] oldest;
    } dma_view_t;

endpackage

>>> rtl/dma_window.sv
// Sample window kept as a shift line (oldest at slot 0), with deadband
// store decision and running sum. Depends on dma_pkg and the assert macros.
`include "deadband_moving_average_top_assert.svh"

module dma_window import dma_pkg::*; #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 19
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_i,
    input  logic [SAMPLE_W-1:0] sample_i,
    input  logic [SAMPLE_W-1:0] thr_i,
    output dma_view_t           view_o,
    output logic [SUM_W-1:0]    sum_o
);

    logic [SAMPLE_W-1:0] slot_reg  [WINDOW];
    logic [SAMPLE_W-1:0] slot_next [WINDOW];
    logic                started_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] newest;
    logic [SAMPLE_W-1:0] diff;
    logic                acc;

    assign newest = slot_reg[WINDOW-1];
    assign diff   = (sample_i >= newest) ? sample_i - newest : newest - sample_i;

    always_comb begin
        slot_next = slot_reg;
        sum_next  = sum_reg;
        acc       = 1'b0;
        if (!started_reg) begin
            // first item fills the whole window; later items go through the deadband check
            for (int i = 0; i < WINDOW; i++) begin
                slot_next[i] = sample_i;
            end
            sum_next = SUM_W'(sample_i) * SUM_W'(WINDOW);
            acc      = 1'b1;
        end else if (diff >= thr_i) begin
            // drop the oldest, append the new sample
            for (int i = 0; i < WINDOW - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
            slot_next[WINDOW-1] = sample_i;
            sum_next = sum_reg - SUM_W'(slot_reg[0]) + SUM_W'(sample_i);
            acc      = 1'b1;
        end
    end

    assign view_o.accepted = acc;
    assign view_o.newest   = slot_next[WINDOW-1];
    assign view_o.oldest   = slot_next[0];
    assign sum_o           = sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            sum_reg     <= '0;
        end else if (load_i) begin
            started_reg <= 1'b1;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            slot_reg <= slot_next;
        end
    end

    `DMA_ASSERT_IMPL(a_first_item_stored, load_i && !started_reg, view_o.accepted)
    `DMA_ASSERT_NEXT(a_started_after_load, load_i, started_reg)
    `DMA_ASSERT_NEXT(a_sum_held_on_reject, load_i && !view_o.accepted,
                     sum_reg == $past(sum_reg))

endmodule

>>> rtl/dma_avg.sv
// Average with 4 fraction bits: (sum * 16) / WINDOW, truncated, by an exact
// reciprocal multiply. Depends on dma_pkg.
module dma_avg import dma_pkg::*; #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 19
) (
    input  logic [SUM_W-1:0] sum_i,
    output logic [AVG_W-1:0] avg_o
);

    localparam int N   = SUM_W + 4;
    localparam int L   = $clog2(WINDOW);
    localparam int SH  = N + L;
    localparam int MW  = N + 1;
    localparam int PW  = N + MW;
    // ceil(2^SH / WINDOW) gives an exact quotient for every N-bit dividend
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    logic [N-1:0]  scaled;
    logic [MW-1:0] recip;
    logic [PW-1:0] prod;

    assign scaled = {sum_i, 4'b0000};
    assign recip  = MW'(RECIP);
    assign prod   = PW'(scaled) * PW'(recip);
    assign avg_o  = prod[SH +: AVG_W];

endmodule

>>> rtl/deadband_moving_average_top.sv
// Top level of the deadband moving average: input register, window update,
// result register and average. Depends on dma_pkg, dma_window, dma_avg.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------
//  input   | s_sample                      | s_valid / s_ready
//  result  | m_accepted .. m_average_q4    | m_valid / m_ready
//  config  | cfg_wdata (change threshold)  | cfg_we, no wait
//
// One item per cycle sustained while m_ready does not stall the result;
// items pass the input register, then the result register. The window
// update (compare, add/subtract) sits between them; the average multiply
// follows the result register. Synchronous active-low reset clears the
// window's started flag, sum, threshold and both valid flags. A stalled
// result holds the input register, which keeps taking items while the result stage has room.
`include "deadband_moving_average_top_assert.svh"

module deadband_moving_average_top import dma_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic [SAMPLE_W-1:0] m_newest_value,
    output logic [SAMPLE_W-1:0] m_oldest_value,
    output logic [WSUM_W-1:0]   m_window_sum,
    output logic [AVG_W-1:0]    m_average_q4
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int EXT_W = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;

    logic [SAMPLE_W-1:0] thr_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                res_valid_reg;
    dma_view_t           res_view_reg;
    logic [SUM_W-1:0]    res_sum_reg;
    logic                adv;
    dma_view_t           view;
    logic [SUM_W-1:0]    sum;
    logic [EXT_W-1:0]    sum_ext;

    assign adv     = in_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= '0;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        if (adv) begin
            res_view_reg <= view;
            res_sum_reg  <= sum;
        end
    end

    dma_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (adv),
        .sample_i (in_sample_reg),
        .thr_i    (thr_reg),
        .view_o   (view),
        .sum_o    (sum)
    );

    dma_avg #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_avg (
        .sum_i (res_sum_reg),
        .avg_o (m_average_q4)
    );

    // saturate the reported sum at the 19-bit range
    assign sum_ext        = EXT_W'(res_sum_reg);
    assign m_window_sum   = (sum_ext > EXT_W'(WSUM_MAX)) ? WSUM_MAX : sum_ext[WSUM_W-1:0];
    assign m_valid        = res_valid_reg;
    assign m_accepted     = res_view_reg.accepted;
    assign m_newest_value = res_view_reg.newest;
    assign m_oldest_value = res_view_reg.oldest;

    `DMA_ASSERT_IMPL(a_stall_only_when_full, !s_ready,
                     in_valid_reg && res_valid_reg && !m_ready)
    `DMA_ASSERT_NEXT(a_advance_fills_result, adv, res_valid_reg)

endmodule
